// ===== rtl/pira_pkg.sv =====
package pira_pkg;

  localparam int TIME_W  = 8;
  localparam int NUM_W   = 16;
  localparam int RATE_W  = 15;
  localparam int DIV_W   = 16;
  localparam int DVR_W   = 8;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ITEM_MAX   = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd1;

  localparam logic [TIME_W-1:0] MIN_INTERVAL_RST   = 8'd1;
  localparam logic [NUM_W-1:0]  RATE_NUMERATOR_RST = 16'd600;
  localparam logic [RATE_W-1:0] RATE_MAX           = 15'h7fff;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_sel_rate;
    logic div_step;
    logic avg_store;
    logic rate_store;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic gap_ok;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pulse_interval_rate_averager_top.sv =====
// Pulse interval rate averager.
// Input channel: in_valid / in_stall carry one capture timestamp per transaction.
// The interval to the previous timestamp goes into a moving window of WINDOW
// entries when it exceeds min_interval; the mean interval and the rate
// (rate_numerator / mean, saturated to 15 bits) are recomputed, otherwise held.
// Output channel: out_valid / out_stall, one result transaction per input.
// Configuration: cfg_valid / cfg_ready (always ready); index 0 is min_interval,
// index 1 is rate_numerator, other indexes are dropped. Write only while idle.
// An accepted interval runs two 16-step restoring divisions on one shared
// divider, one bit per cycle; a rejected one skips them. No new input is taken
// until the result loads; the next one is taken in the cycle after that.
// The finished result sits in an output register; a new input is taken while it
// waits, and the next result is held back until the receiver takes the old one.
// Reset (synchronous, rst_n low) clears the timestamp history, the window
// position and fill flag, the running sum and the held average and rate;
// min_interval returns to 1, rate_numerator to 600. No clearing pass is needed.
module pulse_interval_rate_averager_top #(
  parameter int WINDOW = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pira_pkg::TIME_W-1:0]        in_capture_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_accepted,
  output logic [pira_pkg::TIME_W-1:0]        out_interval,
  output logic [pira_pkg::TIME_W-1:0]        out_average_interval,
  output logic [pira_pkg::RATE_W-1:0]        out_pulses_per_minute,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pira_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pira_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pira_pkg::*;

  cmd_t    cmd;
  status_t st;

  logic [TIME_W-1:0] min_interval_r;
  logic [NUM_W-1:0]  rate_numerator_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r   <= MIN_INTERVAL_RST;
      rate_numerator_r <= RATE_NUMERATOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_INTERVAL:   min_interval_r   <= cfg_data[TIME_W-1:0];
        CFG_RATE_NUMERATOR: rate_numerator_r <= cfg_data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  pira_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pira_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_capture_time       (in_capture_time),
    .min_interval          (min_interval_r),
    .rate_numerator        (rate_numerator_r),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_accepted          (out_accepted),
    .out_interval          (out_interval),
    .out_average_interval  (out_average_interval),
    .out_pulses_per_minute (out_pulses_per_minute)
  );

  // an accepted transaction makes the block busy, so in_stall is raised before another input can be taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in consecutive cycles");

  // an averaged interval is nonzero, so its mean can never be zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_average_interval != '0))
    else $error("zero average reported for an accepted interval");

endmodule

// ===== rtl/pira_ctrl.sv =====
module pira_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pira_pkg::status_t st,
  output pira_pkg::cmd_t    cmd
);
  import pira_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CHECK    = 6'b000010,
    S_LOAD_AVG = 6'b000100,
    S_AVG      = 6'b001000,
    S_RATE     = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.gap_ok) begin
          cmd.update = 1'b1;
          state_nxt  = S_LOAD_AVG;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_LOAD_AVG: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_AVG;
      end
      S_AVG: begin
        if (st.div_done) begin
          // chain straight into the rate division with the fresh average
          cmd.avg_store    = 1'b1;
          cmd.div_start    = 1'b1;
          cmd.div_sel_rate = 1'b1;
          state_nxt        = S_RATE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RATE: begin
        if (st.div_done) begin
          cmd.rate_store = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pira_dp.sv =====
module pira_dp #(
  parameter int WINDOW = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pira_pkg::cmd_t                 cmd,
  output pira_pkg::status_t              st,
  input  logic [pira_pkg::TIME_W-1:0]    in_capture_time,
  input  logic [pira_pkg::TIME_W-1:0]    min_interval,
  input  logic [pira_pkg::NUM_W-1:0]     rate_numerator,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [pira_pkg::TIME_W-1:0]    out_interval,
  output logic [pira_pkg::TIME_W-1:0]    out_average_interval,
  output logic [pira_pkg::RATE_W-1:0]    out_pulses_per_minute
);
  import pira_pkg::*;

  localparam int PW    = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * ITEM_MAX + 1);
  localparam logic [PW-1:0]    POS_LAST  = PW'(WINDOW - 1);
  localparam logic [DVR_W-1:0] WINDOW_DV = DVR_W'(WINDOW);

  logic [TIME_W-1:0] ring_mem [WINDOW];
  logic [TIME_W-1:0] rd_data_r;

  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] gap_r;
  logic [PW-1:0]     pos_r;
  logic [PW-1:0]     pos_nxt;
  logic              filled_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [TIME_W-1:0] old_val;
  logic [TIME_W-1:0] held_avg_r;
  logic [RATE_W-1:0] held_rate_r;

  logic [DIV_W-1:0]  quo_r;
  logic [DVR_W-1:0]  rem_r;
  logic [DVR_W-1:0]  dvr_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [DVR_W:0]    shifted;
  logic              ge;
  logic [DVR_W-1:0]  count_dv;

  logic              out_valid_r;
  logic              out_accepted_r;
  logic [TIME_W-1:0] out_interval_r;
  logic [TIME_W-1:0] out_avg_r;
  logic [RATE_W-1:0] out_ppm_r;

  // slots ahead of the write pointer count as zero until the first wrap sets filled_r
  assign old_val = filled_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(gap_r);
  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
  assign count_dv = filled_r ? WINDOW_DV : DVR_W'(pos_r);

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dvr_r});

  assign st.gap_ok   = (gap_r > min_interval);
  assign st.div_done = (dcnt_r == '0);
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= ring_mem[pos_r];
    end
    if (cmd.update) begin
      ring_mem[pos_r] <= gap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gap_r <= in_capture_time - prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
      sum_r       <= '0;
      held_avg_r  <= '0;
      held_rate_r <= '0;
    end else begin
      if (cmd.capture) begin
        prev_r <= in_capture_time;
      end
      if (cmd.update) begin
        sum_r <= sum_nxt;
        pos_r <= pos_nxt;
        if (pos_r == POS_LAST) begin
          filled_r <= 1'b1;
        end
      end
      if (cmd.avg_store) begin
        held_avg_r <= quo_r[TIME_W-1:0];
      end
      if (cmd.rate_store) begin
        held_rate_r <= quo_r[DIV_W-1] ? RATE_MAX : quo_r[RATE_W-1:0];
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DCNT_W'(DIV_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      if (cmd.div_sel_rate) begin
        quo_r <= DIV_W'(rate_numerator);
        dvr_r <= DVR_W'(quo_r[TIME_W-1:0]);
      end else begin
        quo_r <= DIV_W'(sum_r);
        dvr_r <= count_dv;
      end
    end else if (cmd.div_step) begin
      rem_r <= ge ? DVR_W'(shifted - {1'b0, dvr_r}) : shifted[DVR_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted_r <= st.gap_ok;
      out_interval_r <= gap_r;
      out_avg_r      <= held_avg_r;
      out_ppm_r      <= held_rate_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = out_accepted_r;
  assign out_interval          = out_interval_r;
  assign out_average_interval  = out_avg_r;
  assign out_pulses_per_minute = out_ppm_r;

endmodule

// ===== tb/pulse_interval_rate_averager_top_tb.sv =====
`timescale 1ns / 1ps

module pulse_interval_rate_averager_top_tb;
  import pira_pkg::*;

  localparam int WINDOW = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_TAIL = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic              accepted;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] average_interval;
    logic [RATE_W-1:0] pulses_per_minute;
  } rate_result_t;

  class interval_rate_scoreboard;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] interval_window [WINDOW];
    int unsigned       slot;
    bit                window_full;
    int unsigned       interval_sum;
    logic [TIME_W-1:0] avg_hold;
    logic [RATE_W-1:0] rate_hold;
    logic [TIME_W-1:0] min_gap;
    logic [NUM_W-1:0]  numerator;
    rate_result_t      results_due [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       averaged;

    function new();
      last_time = '0;
      foreach (interval_window[i]) interval_window[i] = '0;
      slot = 0;
      window_full = 1'b0;
      interval_sum = 0;
      avg_hold = '0;
      rate_hold = '0;
      min_gap = MIN_INTERVAL_RST;
      numerator = RATE_NUMERATOR_RST;
      errors = 0;
      checked = 0;
      averaged = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MIN_INTERVAL) begin
        min_gap = data[TIME_W-1:0];
      end else if (idx == CFG_RATE_NUMERATOR) begin
        numerator = data[NUM_W-1:0];
      end
    endfunction

    function void note_capture(logic [TIME_W-1:0] stamp);
      rate_result_t      r;
      logic [TIME_W-1:0] gap;
      int unsigned       entries;
      int unsigned       quotient;
      gap = stamp - last_time;
      last_time = stamp;
      r.accepted = gap > min_gap;
      if (r.accepted) begin
        interval_sum = interval_sum - interval_window[slot] + gap;
        interval_window[slot] = gap;
        slot++;
        if (slot == WINDOW) begin
          slot = 0;
          window_full = 1'b1;
        end
        entries = window_full ? WINDOW : slot;
        avg_hold = TIME_W'(interval_sum / entries);
        if (avg_hold == 0) begin
          rate_hold = RATE_MAX;
        end else begin
          quotient = numerator / avg_hold;
          rate_hold = (quotient > RATE_MAX) ? RATE_MAX : RATE_W'(quotient);
        end
      end
      r.interval = gap;
      r.average_interval = avg_hold;
      r.pulses_per_minute = rate_hold;
      results_due.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic acc, logic [TIME_W-1:0] ivl, logic [TIME_W-1:0] avg,
                      logic [RATE_W-1:0] ppm);
      rate_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with nothing outstanding (interval %0d)", ivl));
      end else begin
        want = results_due.pop_front();
        checked++;
        if (want.accepted) averaged++;
        if (acc !== want.accepted)
          report($sformatf("accepted got %0b want %0b", acc, want.accepted));
        if (ivl !== want.interval)
          report($sformatf("interval got %0d want %0d", ivl, want.interval));
        if (avg !== want.average_interval)
          report($sformatf("average_interval got %0d want %0d", avg,
                           want.average_interval));
        if (ppm !== want.pulses_per_minute)
          report($sformatf("pulses_per_minute got %0d want %0d", ppm,
                           want.pulses_per_minute));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_capture_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_accepted;
  logic [TIME_W-1:0]     out_interval;
  logic [TIME_W-1:0]     out_average_interval;
  logic [RATE_W-1:0]     out_pulses_per_minute;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  interval_rate_scoreboard sb = new();

  bit                calm = 1'b0;
  bit                hold_go = 1'b0;
  logic              hold_active = 1'b0;
  int                stall_left = 0;
  int                cycle_count = 0;
  int unsigned       captures_sent = 0;
  int unsigned       settings_used = 0;
  logic [TIME_W-1:0] last_sent = '0;
  logic [TIME_W-1:0] cur_min = MIN_INTERVAL_RST;

  pulse_interval_rate_averager_top #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_capture_time      (in_capture_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_interval         (out_interval),
    .out_average_interval (out_average_interval),
    .out_pulses_per_minute(out_pulses_per_minute),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pulse_interval_rate_averager_top verification failed");
    $finish;
  end

  // Result side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_accepted, out_interval, out_average_interval,
                      out_pulses_per_minute);
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active <= 1'b0;
  end

  task send_capture(input logic [TIME_W-1:0] stamp);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_capture_time <= stamp;
    do @(posedge clk); while (in_stall);
    sb.note_capture(stamp);
    last_sent = stamp;
    captures_sent++;
  endtask

  task wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.results_due.size() != 0);
  endtask

  task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Upper data bits of the min_interval write must be dropped; spare indexes ignored.
  task program_regs(input logic [TIME_W-1:0] min_v, input logic [NUM_W-1:0] num_v);
    logic [TIME_W-1:0] junk;
    junk = TIME_W'($urandom);
    cfg_write(CFG_MIN_INTERVAL, {junk, min_v});
    cfg_write(CFG_RATE_NUMERATOR, num_v);
    cfg_write(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_min = min_v;
    settings_used++;
  endtask

  task run_random_phase(input int items, input bit mid_pause);
    int spread;
    int pick;
    int delta;
    spread = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(4, 60);
    for (int i = 0; i < items; i++) begin
      if (mid_pause && i == items / 2) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        delta = cur_min + 1 + $urandom_range(0, spread);
        send_capture(TIME_W'(last_sent + delta));
      end else if (pick < 90) begin
        delta = $urandom_range(0, cur_min);
        send_capture(TIME_W'(last_sent + delta));
      end else begin
        send_capture(TIME_W'($urandom));
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first capture measured from zero, then a gap equal to
    // the minimum, a small accepted gap, a large gap, the largest gap and a zero gap.
    send_capture(8'd0);
    send_capture(8'd1);
    send_capture(8'd3);
    send_capture(8'd255);
    send_capture(8'd254);
    send_capture(8'd254);
    wait_results_drained();

    // No minimum, full numerator: flush the window with unit gaps to saturate.
    program_regs(8'd0, 16'hffff);
    for (int i = 0; i < 10; i++) send_capture(TIME_W'(last_sent + 1));
    send_capture(last_sent);
    wait_results_drained();

    program_regs(8'd1, 16'd0);
    send_capture(TIME_W'(last_sent + 3));
    wait_results_drained();

    // Largest minimum rejects everything; the held values carry over.
    program_regs(8'd255, 16'd1);
    send_capture(TIME_W'(last_sent + 255));
    send_capture(TIME_W'(last_sent + 100));
    wait_results_drained();

    program_regs(8'd1, 16'd1);
    send_capture(TIME_W'(last_sent + 2));
    send_capture(TIME_W'(last_sent + 200));
    wait_results_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_regs(8'd1, 16'd600);
        1: program_regs(8'd0, 16'hffff);
        2: program_regs(8'd255, 16'd1);
        3: program_regs(8'd0, 16'd0);
        default: program_regs(($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 255))
                                                         : TIME_W'($urandom_range(1, 30)),
                              ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(1, 1000))
                                                         : NUM_W'($urandom));
      endcase
      if (ph == 4) hold_go = 1'b1;
      if (ph == 9) calm = 1'b1;
      run_random_phase((ph == 2) ? 40 : 160, ph == 5);
    end

    wait_results_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.results_due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.results_due.size()));

    $display("Run covered %0d captures over %0d register settings: %0d results checked,",
             captures_sent, settings_used, sb.checked);
    $display("%0d of them averaged, %0d mismatches.", sb.averaged, sb.errors);
    if (sb.errors == 0) begin
      $display("pulse_interval_rate_averager_top verification clean");
    end else begin
      $display("pulse_interval_rate_averager_top verification failed");
    end
    $finish;
  end

endmodule
